@@ src/apm_pkg.sv @@
// Shared types and constants for the audio playback mode engine.
// Used by every module of the block; depends on nothing.
package apm_pkg;

  // Delay memory geometry.
  localparam int MAX_DELAY_FRAMES = 32768;
  localparam int ADDR_W = $clog2(MAX_DELAY_FRAMES);
  localparam int WORD_W = 16;
  localparam int DELAY_W = 16;
  localparam int FILL_W = 16;
  // Width that holds both delay_frames and MAX_DELAY_FRAMES for compares.
  localparam int LEN_W = DELAY_W + 1;
  localparam logic [FILL_W-1:0] FILL_SAT = {FILL_W{1'b1}};

  // Configuration port.
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAMES = 2'd1;
  localparam logic [DELAY_W-1:0] DELAY_FRAMES_RESET = 16'd22050;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_DRAIN = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Playback modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;
  localparam logic [1:0] MODE_DELAY = 2'd3;

  // Result pattern of one item.
  typedef enum logic [2:0] {
    PAT_PAIR,
    PAT_SINGLE,
    PAT_QUAD,
    PAT_TAP,
    PAT_DRAIN
  } pat_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] sample;
    logic              last;
  } out_item_t;

  // Access to the delay memory.
  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  // Item handed from the tap controller to the result sequencer.
  typedef struct packed {
    logic              valid;
    pat_t              pat;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
    logic              tap_zero;
  } load_t;

endpackage

@@ src/apm_delay_ram.sv @@
// Single-port delay memory with a registered, read-first output.
// Depends on apm_pkg for geometry and the request struct.
module apm_delay_ram (
  input  logic                      clk,
  input  apm_pkg::ram_req_t         req,
  output logic [apm_pkg::WORD_W-1:0] rdata
);
  import apm_pkg::*;

  logic [WORD_W-1:0] mem [MAX_DELAY_FRAMES];

  // Read returns the old word when the same entry is written in the cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ src/apm_tap_ctrl.sv @@
// Decodes accepted items, keeps the delay pointer and fill count, and
// issues delay memory accesses. Depends on apm_pkg.
module apm_tap_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  apm_pkg::in_item_t           item,
  input  logic [1:0]                  play_mode,
  input  logic [apm_pkg::DELAY_W-1:0] delay_frames,
  output apm_pkg::ram_req_t           ram_req,
  output apm_pkg::load_t              load
);
  import apm_pkg::*;

  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  frames_ext;
  logic [LEN_W-1:0]  slot;
  logic [LEN_W-1:0]  slot_inc;
  logic              tap_en;
  logic              store;

  // Delay length clamped into 1 .. MAX_DELAY_FRAMES.
  always_comb begin
    frames_ext = {1'b0, delay_frames};
    if (frames_ext == '0) begin
      len = LEN_W'(1);
    end else if (frames_ext > LEN_W'(MAX_DELAY_FRAMES)) begin
      len = LEN_W'(MAX_DELAY_FRAMES);
    end else begin
      len = frames_ext;
    end
  end

  // Slot used by this item, and the one after it.
  always_comb begin
    slot = LEN_W'(ptr);
    if (slot >= len) begin
      slot = '0;
    end
    slot_inc = slot + LEN_W'(1);
    if (slot_inc >= len) begin
      slot_inc = '0;
    end
  end

  // Command decode, pointer and fill count update, memory access.
  always_comb begin
    tap_en = 1'b0;
    store = 1'b0;
    load.valid = 1'b0;
    load.pat = PAT_PAIR;
    load.left = item.first_word;
    load.right = item.second_word;
    load.tap_zero = slot >= LEN_W'(fill);
    ptr_next = ptr;
    fill_next = fill;
    case (item.command)
      CMD_RESTART: begin
        ptr_next = '0;
        fill_next = '0;
      end
      CMD_DRAIN: begin
        if (play_mode == MODE_DELAY) begin
          tap_en = 1'b1;
          load.valid = 1'b1;
          load.pat = PAT_DRAIN;
        end
      end
      CMD_DATA: begin
        load.valid = 1'b1;
        case (play_mode)
          MODE_DOUBLE: load.pat = PAT_SINGLE;
          MODE_HALF:   load.pat = PAT_QUAD;
          MODE_DELAY: begin
            load.pat = PAT_TAP;
            tap_en = 1'b1;
            store = 1'b1;
          end
          default:     load.pat = PAT_PAIR;
        endcase
      end
      default: begin
      end
    endcase
    if (tap_en) begin
      ptr_next = slot_inc[ADDR_W-1:0];
      if (store && slot == LEN_W'(fill) && fill != FILL_SAT) begin
        fill_next = fill + FILL_W'(1);
      end
    end
    if (!accept) begin
      tap_en = 1'b0;
      store = 1'b0;
      load.valid = 1'b0;
      ptr_next = ptr;
      fill_next = fill;
    end
    ram_req.re = tap_en;
    ram_req.we = store;
    ram_req.addr = slot[ADDR_W-1:0];
    ram_req.wdata = item.second_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      fill <= '0;
    end else begin
      ptr <= ptr_next;
      fill <= fill_next;
    end
  end

endmodule

@@ src/apm_result_seq.sv @@
// Holds one decoded item and sends its results, one per cycle unless out_ready stalls
// them, through an output register. Depends on apm_pkg.
module apm_result_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  apm_pkg::load_t              load,
  input  logic [apm_pkg::WORD_W-1:0]  tap_data,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output apm_pkg::out_item_t          out_data
);
  import apm_pkg::*;

  logic              hold_valid;
  pat_t              hold_pat;
  logic [WORD_W-1:0] hold_left;
  logic [WORD_W-1:0] hold_right;
  logic              hold_zero;
  logic [1:0]        pos;
  logic [1:0]        last_pos;
  logic [WORD_W-1:0] tap_word;
  logic [WORD_W-1:0] sample_sel;
  logic              push;
  logic              done;

  // Word chosen for the current position of the held item.
  always_comb begin
    tap_word = hold_zero ? '0 : tap_data;
    case (hold_pat)
      PAT_SINGLE: begin
        last_pos = 2'd0;
        sample_sel = hold_left;
      end
      PAT_QUAD: begin
        last_pos = 2'd3;
        sample_sel = pos[1] ? hold_right : hold_left;
      end
      PAT_TAP: begin
        last_pos = 2'd1;
        sample_sel = pos[0] ? tap_word : hold_left;
      end
      PAT_DRAIN: begin
        last_pos = 2'd1;
        sample_sel = pos[0] ? tap_word : '0;
      end
      default: begin
        last_pos = 2'd1;
        sample_sel = pos[0] ? hold_right : hold_left;
      end
    endcase
  end

  assign push = hold_valid && (!out_valid || out_ready);
  assign done = push && (pos == last_pos);
  assign in_ready = !hold_valid || done;

  // Held item and its result position.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pos <= '0;
    end else if (load.valid) begin
      hold_valid <= 1'b1;
      pos <= '0;
    end else if (done) begin
      hold_valid <= 1'b0;
    end else if (push) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      hold_pat <= load.pat;
      hold_left <= load.left;
      hold_right <= load.right;
      hold_zero <= load.tap_zero;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.sample <= sample_sel;
      out_data.last <= (pos == last_pos);
    end
  end

endmodule

@@ src/audio_playback_mode_engine.sv @@
// Audio playback mode engine: the first result of an item passes through the held-item
// register and then the output register. A new item is taken as the last result of the
// held one is sent. An item gives 4 results in half speed, 2 in normal and delay modes and
// for a drain in delay mode, 1 in double speed, none for a restart or another drain.
// Synchronous reset returns the configuration to its reset values and clears the delay
// pointer and fill count; the delay memory is not cleared, entries at or past the fill
// count read as zero.
module audio_playback_mode_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  apm_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output apm_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [apm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apm_pkg::CFG_W-1:0]     cfg_data
);
  import apm_pkg::*;

  logic [1:0]         play_mode;
  logic [DELAY_W-1:0] delay_frames;
  logic               accept;
  ram_req_t           ram_req;
  load_t              load;
  logic [WORD_W-1:0]  tap_data;

  assign accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode <= MODE_NORMAL;
      delay_frames <= DELAY_FRAMES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAY_MODE:    play_mode <= cfg_data[1:0];
        REG_DELAY_FRAMES: delay_frames <= cfg_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apm_tap_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (in_data),
    .play_mode    (play_mode),
    .delay_frames (delay_frames),
    .ram_req      (ram_req),
    .load         (load)
  );

  apm_delay_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (tap_data)
  );

  apm_result_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .tap_data  (tap_data),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The delay memory is written only by a data item in delay mode.
  a_write_only_delay_data: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> accept && in_data.command == CMD_DATA && play_mode == MODE_DELAY)
    else $error("delay memory written by an item that stores nothing");

  // Any memory access belongs to an accepted item.
  a_read_on_accept: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |-> accept)
    else $error("delay memory read without an accepted item");

  // After a data item is accepted, the output holds a valid result once it reaches the output register.
  a_data_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.command == CMD_DATA |-> ##2 out_valid)
    else $error("data item produced no result");

  // A restart never starts a result sequence.
  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.command == CMD_RESTART |-> !load.valid)
    else $error("restart item loaded a result sequence");
`endif

endmodule
